FILE: design/mcr_pkg.sv
package mcr_pkg;

	localparam int COORD_WIDTH_DEF = 12;
	localparam int OUT_W           = 13;
	localparam int STEP_X_W        = 11;
	localparam int STEP_Y_W        = 12;
	localparam int DEC_W           = 14;
	localparam int RAD_W           = 10;
	localparam int COLOR_W         = 24;
	localparam int WIN_W           = 11;
	localparam int CFG_IDX_W       = 2;

	localparam logic [WIN_W-1:0] WIN_WIDTH_RST  = WIN_W'(800);
	localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = WIN_W'(500);

	localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = CFG_IDX_W'(1);

	// output slots: eight octant points, four spans, one status word
	localparam int NSLOT       = 13;
	localparam int SLOT_W      = 4;
	localparam int SLOT_STATUS = 12;

	localparam logic [NSLOT-1:0] MASK_TOP      = NSLOT'(13'h0001);
	localparam logic [NSLOT-1:0] MASK_POINTS   = NSLOT'(13'h00FF);
	localparam logic [NSLOT-1:0] MASK_MID_SPAN = NSLOT'(13'h0100);
	localparam logic [NSLOT-1:0] MASK_SPANS    = NSLOT'(13'h0F00);
	localparam logic [NSLOT-1:0] MASK_STATUS   = NSLOT'(13'h1000);

	typedef enum logic [1:0] {
		KIND_POINT,
		KIND_SPAN,
		KIND_STATUS
	} kind_t;

	typedef enum logic {
		ACT_START,
		ACT_ADVANCE
	} action_t;

	typedef struct packed {
		logic [NSLOT-1:0] mask;
		logic             done;
	} job_ctl_t;

	// swap: column offset is y and row offset is x
	typedef struct packed {
		logic swap;
		logic neg_col;
		logic neg_row;
	} slot_sel_t;

	localparam slot_sel_t SLOT_TAB [NSLOT] = '{
		'{1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b1},
		'{1'b1, 1'b0, 1'b0},
		'{1'b1, 1'b1, 1'b0},
		'{1'b1, 1'b1, 1'b1},
		'{1'b1, 1'b0, 1'b1},
		'{1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b1},
		'{1'b1, 1'b0, 1'b1},
		'{1'b0, 1'b0, 1'b0}
	};

endpackage

FILE: design/mcr_step.sv
module mcr_step #(
	parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic                                  action,
	input  logic signed [COORD_WIDTH-1:0]         center_x,
	input  logic signed [COORD_WIDTH-1:0]         center_y,
	input  logic [mcr_pkg::RAD_W-1:0]             radius,
	input  logic                                  fill_request,
	input  logic [mcr_pkg::COLOR_W-1:0]           pixel_color,
	output mcr_pkg::job_ctl_t                     job_ctl,
	output logic signed [COORD_WIDTH-1:0]         job_a,
	output logic signed [COORD_WIDTH-1:0]         job_b,
	output logic [mcr_pkg::STEP_X_W-1:0]          job_x,
	output logic signed [mcr_pkg::STEP_Y_W-1:0]   job_y,
	output logic [mcr_pkg::COLOR_W-1:0]           job_color
);
	import mcr_pkg::*;

	logic [STEP_X_W-1:0]           x_q;
	logic signed [STEP_Y_W-1:0]    y_q;
	logic signed [DEC_W-1:0]       d_q;
	logic signed [COORD_WIDTH-1:0] a_q;
	logic signed [COORD_WIDTH-1:0] b_q;
	logic                          fill_q;
	logic [COLOR_W-1:0]            color_q;
	logic                          active_q;

	logic                          is_start;
	logic                          run_end;
	logic [STEP_X_W-1:0]           x_next;
	logic signed [STEP_Y_W-1:0]    y_next;
	logic signed [DEC_W-1:0]       d_next;
	logic signed [DEC_W-1:0]       two_x;
	logic signed [DEC_W-2:0]       x_minus_y;
	logic signed [DEC_W-1:0]       two_xy;
	logic                          fin;
	logic signed [STEP_Y_W-1:0]    y_start;
	logic signed [DEC_W-1:0]       d_start;

	always_comb begin
		is_start  = (action == ACT_START);
		run_end   = !active_q || (y_q < $signed({1'b0, x_q}));
		two_x     = $signed({2'b00, x_q, 1'b0});
		x_minus_y = $signed({2'b00, x_q}) - (DEC_W-1)'(y_q);
		two_xy    = $signed({x_minus_y, 1'b0});
		x_next    = x_q + STEP_X_W'(1);
		if (d_q < 0) begin
			d_next = d_q + two_x + DEC_W'(3);
			y_next = y_q;
		end else begin
			d_next = d_q + two_xy + DEC_W'(5);
			y_next = y_q - STEP_Y_W'(1);
		end
		fin     = y_next < $signed({1'b0, x_next});
		y_start = $signed(STEP_Y_W'(radius));
		d_start = DEC_W'(1) - $signed(DEC_W'(radius));

		job_a     = a_q;
		job_b     = b_q;
		job_x     = x_q;
		job_y     = y_q;
		job_color = color_q;
		if (is_start) begin
			job_ctl.mask = MASK_TOP | (fill_request ? MASK_MID_SPAN : '0) | MASK_STATUS;
			job_ctl.done = 1'b0;
			job_a        = center_x;
			job_b        = center_y;
			job_x        = '0;
			job_y        = y_start;
			job_color    = pixel_color;
		end else if (run_end) begin
			job_ctl.mask = MASK_STATUS;
			job_ctl.done = 1'b1;
		end else begin
			job_ctl.mask = MASK_POINTS | (fill_q ? MASK_SPANS : '0) | MASK_STATUS;
			job_ctl.done = fin;
			job_x        = x_next;
			job_y        = y_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			fill_q   <= 1'b0;
			color_q  <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				a_q      <= center_x;
				b_q      <= center_y;
				fill_q   <= fill_request;
				color_q  <= pixel_color;
				x_q      <= '0;
				y_q      <= y_start;
				d_q      <= d_start;
				active_q <= 1'b1;
			end else if (run_end) begin
				active_q <= 1'b0;
			end else begin
				x_q      <= x_next;
				y_q      <= y_next;
				d_q      <= d_next;
				active_q <= !fin;
			end
		end
	end

endmodule

FILE: design/mcr_emit.sv
module mcr_emit #(
	parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  mcr_pkg::job_ctl_t                     job_ctl,
	input  logic signed [COORD_WIDTH-1:0]         job_a,
	input  logic signed [COORD_WIDTH-1:0]         job_b,
	input  logic [mcr_pkg::STEP_X_W-1:0]          job_x,
	input  logic signed [mcr_pkg::STEP_Y_W-1:0]   job_y,
	input  logic [mcr_pkg::COLOR_W-1:0]           job_color,
	input  logic [mcr_pkg::WIN_W-1:0]             win_width,
	input  logic [mcr_pkg::WIN_W-1:0]             win_height,
	output logic                                  job_free,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output mcr_pkg::kind_t                        kind,
	output logic signed [mcr_pkg::OUT_W-1:0]      x_low,
	output logic signed [mcr_pkg::OUT_W-1:0]      x_high,
	output logic signed [mcr_pkg::OUT_W-1:0]      row,
	output logic [mcr_pkg::COLOR_W-1:0]           color_out,
	output logic                                  done_res,
	output logic                                  last
);
	import mcr_pkg::*;

	localparam int IW = (COORD_WIDTH + 2 > OUT_W) ? COORD_WIDTH + 2 : OUT_W;
	localparam logic signed [IW-1:0] ONE = IW'(1);

	job_ctl_t                      ctl_s1;
	logic signed [COORD_WIDTH-1:0] a_s1;
	logic signed [COORD_WIDTH-1:0] b_s1;
	logic [STEP_X_W-1:0]           x_s1;
	logic signed [STEP_Y_W-1:0]    y_s1;
	logic [COLOR_W-1:0]            color_s1;

	logic                          valid_q;
	kind_t                         kind_q;
	logic signed [OUT_W-1:0]       lo_q;
	logic signed [OUT_W-1:0]       hi_q;
	logic signed [OUT_W-1:0]       row_q;
	logic [COLOR_W-1:0]            color_q;
	logic                          done_q;
	logic                          last_q;

	logic [NSLOT-1:0]              pick;
	logic [SLOT_W-1:0]             slot;
	slot_sel_t                     sel;
	logic                          busy;
	logic                          adv;
	logic                          finishing;
	logic signed [IW-1:0]          ax, bx, xe, ye, du, dv;
	logic signed [IW-1:0]          col_lo, col_hi, row_v, pcol;
	logic signed [IW-1:0]          smin, smax, span_lo, span_hi, span_row;
	logic signed [IW-1:0]          wext, hext;
	logic                          in_win;
	logic                          is_point, is_span, is_status, emit_item;
	kind_t                         kind_d;
	logic signed [IW-1:0]          lo_d, hi_d, row_d;

	always_comb begin
		// lowest pending slot goes out first
		pick = ctl_s1.mask & (~ctl_s1.mask + NSLOT'(1));
		slot = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (pick[i]) begin
				slot = slot | SLOT_W'(i);
			end
		end
		sel       = SLOT_TAB[slot];
		busy      = |ctl_s1.mask;
		adv       = busy && (!valid_q || out_ready);
		finishing = adv && pick[SLOT_STATUS];
		job_free  = !busy || finishing;

		ax     = IW'(a_s1);
		bx     = IW'(b_s1);
		xe     = $signed(IW'(x_s1));
		ye     = IW'(y_s1);
		du     = sel.swap ? ye : xe;
		dv     = sel.swap ? xe : ye;
		col_lo = ax - du;
		col_hi = ax + du;
		row_v  = sel.neg_row ? bx - dv : bx + dv;
		pcol   = sel.neg_col ? col_lo : col_hi;
		wext   = $signed(IW'(win_width));
		hext   = $signed(IW'(win_height));
		in_win = (pcol > 0) && (pcol < wext) && (row_v > 0) && (row_v < hext);

		// half-pixel rule of the span walk: negative start lowers both ends, negative row lowers the row
		smin     = (col_lo < col_hi) ? col_lo : col_hi;
		smax     = (col_lo < col_hi) ? col_hi : col_lo;
		span_lo  = (col_lo < 0) ? smin - ONE : smin;
		span_hi  = (col_lo < 0) ? smax - ONE : smax;
		span_row = (row_v < 0) ? row_v - ONE : row_v;

		is_status = pick[SLOT_STATUS];
		is_span   = |(pick & MASK_SPANS);
		is_point  = |(pick & MASK_POINTS);
		emit_item = is_status || is_span || (is_point && in_win);

		if (is_status) begin
			kind_d = KIND_STATUS;
			lo_d   = '0;
			hi_d   = '0;
			row_d  = '0;
		end else if (is_span) begin
			kind_d = KIND_SPAN;
			lo_d   = span_lo;
			hi_d   = span_hi;
			row_d  = span_row;
		end else begin
			kind_d = KIND_POINT;
			lo_d   = pcol;
			hi_d   = pcol;
			row_d  = row_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				ctl_s1 <= job_ctl;
			end else if (adv) begin
				ctl_s1.mask <= ctl_s1.mask & ~pick;
			end
			if (adv) begin
				valid_q <= emit_item;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_s1     <= job_a;
			b_s1     <= job_b;
			x_s1     <= job_x;
			y_s1     <= job_y;
			color_s1 <= job_color;
		end
		if (adv && emit_item) begin
			kind_q  <= kind_d;
			lo_q    <= lo_d[OUT_W-1:0];
			hi_q    <= hi_d[OUT_W-1:0];
			row_q   <= row_d[OUT_W-1:0];
			color_q <= color_s1;
			done_q  <= is_status && ctl_s1.done;
			last_q  <= is_status;
		end
	end

	assign out_valid = valid_q;
	assign kind      = kind_q;
	assign x_low     = lo_q;
	assign x_high    = hi_q;
	assign row       = row_q;
	assign color_out = color_q;
	assign done_res  = done_q;
	assign last      = last_q;

	a_last_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (last_q == (kind_q == KIND_STATUS)))
		else $error("last flag does not match status word");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> job_free)
		else $error("job loaded over a job still in flight");

	a_status_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ctl_s1.mask[SLOT_STATUS])
		else $error("job in flight without its status slot");

	a_point_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && kind_q == KIND_POINT) |-> (lo_q == hi_q && !done_q))
		else $error("point word with unequal ends or done set");

endmodule

FILE: design/midpoint_circle_rasterizer_top.sv
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    action center_x center_y radius fill_request
//                                           pixel_color
// out       output     out_valid/out_ready  kind x_low x_high row color_out done_res last
// cfg       input      cfg_valid/cfg_ready  cfg_index cfg_data
//
// at most one output word per cycle while out_ready is high, from a single slot
// sequencer that walks 13 slots; an advance word uses the point and status slots,
// plus the span slots in fill mode (rejected points still use their slot), a start
// word the top point, the fill-mode middle span and status, an idle advance status only
// the next input word is taken in the cycle its predecessor's status slot issues
// cfg_ready is always high; reset gives 800 x 500 and no circle running
// out_ready low while out_valid is high holds the output register and the sequencer, not the step state
module midpoint_circle_rasterizer_top #(
	parameter int COORD_WIDTH = mcr_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic signed [COORD_WIDTH-1:0]         center_x,
	input  logic signed [COORD_WIDTH-1:0]         center_y,
	input  logic [mcr_pkg::RAD_W-1:0]             radius,
	input  logic                                  fill_request,
	input  logic [mcr_pkg::COLOR_W-1:0]           pixel_color,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output mcr_pkg::kind_t                        kind,
	output logic signed [mcr_pkg::OUT_W-1:0]      x_low,
	output logic signed [mcr_pkg::OUT_W-1:0]      x_high,
	output logic signed [mcr_pkg::OUT_W-1:0]      row,
	output logic [mcr_pkg::COLOR_W-1:0]           color_out,
	output logic                                  done_res,
	output logic                                  last,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mcr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mcr_pkg::WIN_W-1:0]             cfg_data
);
	import mcr_pkg::*;

	logic [WIN_W-1:0]              win_width_q;
	logic [WIN_W-1:0]              win_height_q;
	logic                          accept;
	logic                          job_free;
	job_ctl_t                      job_ctl;
	logic signed [COORD_WIDTH-1:0] job_a;
	logic signed [COORD_WIDTH-1:0] job_b;
	logic [STEP_X_W-1:0]           job_x;
	logic signed [STEP_Y_W-1:0]    job_y;
	logic [COLOR_W-1:0]            job_color;

	assign cfg_ready = 1'b1;
	assign in_ready  = job_free;
	assign accept    = in_valid && job_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_width_q  <= WIN_WIDTH_RST;
			win_height_q <= WIN_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIN_WIDTH:  win_width_q  <= cfg_data;
				CFG_WIN_HEIGHT: win_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mcr_step #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.fill_request(fill_request),
		.pixel_color (pixel_color),
		.job_ctl     (job_ctl),
		.job_a       (job_a),
		.job_b       (job_b),
		.job_x       (job_x),
		.job_y       (job_y),
		.job_color   (job_color)
	);

	mcr_emit #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.job_ctl   (job_ctl),
		.job_a     (job_a),
		.job_b     (job_b),
		.job_x     (job_x),
		.job_y     (job_y),
		.job_color (job_color),
		.win_width (win_width_q),
		.win_height(win_height_q),
		.job_free  (job_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.x_low     (x_low),
		.x_high    (x_high),
		.row       (row),
		.color_out (color_out),
		.done_res  (done_res),
		.last      (last)
	);

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mcr_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int LIMIT_CYC = 200000;
	localparam int SETTLE_CYC = 20;
	localparam int HOLD_CYC = 300;

	typedef struct {
		action_t              act;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [RAD_W-1:0]     rad;
		logic                 fill;
		logic [COLOR_W-1:0]   color;
	} circle_cmd_t;

	typedef struct {
		kind_t                   kind;
		logic signed [OUT_W-1:0] col_lo;
		logic signed [OUT_W-1:0] col_hi;
		logic signed [OUT_W-1:0] row_no;
		logic [COLOR_W-1:0]      color;
		logic                    done;
		logic                    last;
	} draw_word_t;

	// typed rows carry a known status-only answer
	typedef struct {
		bit                 typed;
		logic               t_done;
		logic [COLOR_W-1:0] t_color;
		circle_cmd_t        cmd;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    action;
	logic signed [CW-1:0]    center_x;
	logic signed [CW-1:0]    center_y;
	logic [RAD_W-1:0]        radius;
	logic                    fill_request;
	logic [COLOR_W-1:0]      pixel_color;
	logic                    out_valid;
	logic                    out_ready;
	kind_t                   kind;
	logic signed [OUT_W-1:0] x_low;
	logic signed [OUT_W-1:0] x_high;
	logic signed [OUT_W-1:0] row;
	logic [COLOR_W-1:0]      color_out;
	logic                    done_res;
	logic                    last;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [WIN_W-1:0]        cfg_data;

	// circle tracker state
	int                 win_w;
	int                 win_h;
	int                 px_x;
	int                 px_y;
	int                 px_d;
	int                 ctr_c;
	int                 ctr_r;
	bit                 filling;
	bit                 running;
	logic [COLOR_W-1:0] ink;

	draw_word_t step_words[$];
	draw_word_t draw_q[$];
	draw_word_t seen;
	dir_row_t   dir_tab[25];

	int n_items;
	int n_words;
	int n_err;
	int n_cycles;
	int n_windows;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_left;

	midpoint_circle_rasterizer_top u_top (.*);

	always #1 clk = ~clk;

	function automatic void put_word(kind_t k, int lo, int hi, int r, logic dn);
		draw_word_t w;
		w.kind = k;
		w.col_lo = lo[OUT_W-1:0];
		w.col_hi = hi[OUT_W-1:0];
		w.row_no = r[OUT_W-1:0];
		w.color = ink;
		w.done = dn;
		w.last = (k == KIND_STATUS);
		step_words.push_back(w);
	endfunction

	function automatic void plot(int cx, int cy);
		if (cx > 0 && cx < win_w && cy > 0 && cy < win_h) begin
			put_word(KIND_POINT, cx, cx, cy, 1'b0);
		end
	endfunction

	// half-pixel rule: negative start shifts both ends, negative row shifts the row
	function automatic void spread(int s, int e, int r);
		int sh;
		int lo;
		int hi;
		sh = (s < 0) ? 1 : 0;
		lo = (s < e) ? s : e;
		hi = (s < e) ? e : s;
		put_word(KIND_SPAN, lo - sh, hi - sh, (r < 0) ? r - 1 : r, 1'b0);
	endfunction

	function automatic void trace_circle(input circle_cmd_t c);
		int a;
		int b;
		step_words.delete();
		if (c.act == ACT_START) begin
			ctr_c = c.cx;
			ctr_r = c.cy;
			filling = c.fill;
			ink = c.color;
			px_x = 0;
			px_y = c.rad;
			px_d = 1 - int'(c.rad);
			running = 1'b1;
			plot(ctr_c, ctr_r + px_y);
			if (filling) begin
				spread(ctr_c - px_y, ctr_c + px_y, ctr_r);
			end
			put_word(KIND_STATUS, 0, 0, 0, 1'b0);
		end else if (!running || px_y < px_x) begin
			running = 1'b0;
			put_word(KIND_STATUS, 0, 0, 0, 1'b1);
		end else begin
			if (px_d < 0) begin
				px_d += 2 * px_x + 3;
				px_x++;
			end else begin
				px_d += 2 * (px_x - px_y) + 5;
				px_x++;
				px_y--;
			end
			a = ctr_c;
			b = ctr_r;
			plot(a + px_x, b + px_y);
			plot(a - px_x, b + px_y);
			plot(a - px_x, b - px_y);
			plot(a + px_x, b - px_y);
			plot(a + px_y, b + px_x);
			plot(a - px_y, b + px_x);
			plot(a - px_y, b - px_x);
			plot(a + px_y, b - px_x);
			if (filling) begin
				spread(a - px_y, a + px_y, b + px_x);
				spread(a - px_x, a + px_x, b + px_y);
				spread(a - px_x, a + px_x, b - px_y);
				spread(a - px_y, a + px_y, b - px_x);
			end
			if (px_y < px_x) begin
				running = 1'b0;
				put_word(KIND_STATUS, 0, 0, 0, 1'b1);
			end else begin
				put_word(KIND_STATUS, 0, 0, 0, 1'b0);
			end
		end
	endfunction

	function automatic circle_cmd_t rand_start(input bit wide);
		circle_cmd_t c;
		c.act = ACT_START;
		if (wide) begin
			c.cx = CW'($urandom());
			c.cy = CW'($urandom());
			c.rad = RAD_W'($urandom());
		end else begin
			c.cx = CW'($urandom_range(0, win_w));
			c.cy = CW'($urandom_range(0, win_h));
			c.rad = ($urandom_range(99) < 85) ? RAD_W'($urandom_range(0, 24)) :
				RAD_W'($urandom_range(25, 90));
		end
		c.fill = 1'($urandom());
		c.color = COLOR_W'($urandom());
		return c;
	endfunction

	// centre, radius, fill and colour are don't-care on advance
	function automatic circle_cmd_t rand_advance();
		circle_cmd_t c;
		c.act = ACT_ADVANCE;
		c.cx = CW'($urandom());
		c.cy = CW'($urandom());
		c.rad = RAD_W'($urandom());
		c.fill = 1'($urandom());
		c.color = COLOR_W'($urandom());
		return c;
	endfunction

	// entered and left at a falling edge
	task automatic send_cmd(input circle_cmd_t c, input bit typed = 1'b0,
			input logic t_done = 1'b0, input logic [COLOR_W-1:0] t_color = '0);
		draw_word_t w;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = c.act;
		center_x = c.cx;
		center_y = c.cy;
		radius = c.rad;
		fill_request = c.fill;
		pixel_color = c.color;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		trace_circle(c);
		if (typed) begin
			w = '{KIND_STATUS, '0, '0, '0, t_color, t_done, 1'b1};
			draw_q.push_back(w);
		end else begin
			foreach (step_words[i]) begin
				draw_q.push_back(step_words[i]);
			end
		end
		n_items++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (draw_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic set_window(input int w, input int h);
		cfg_valid = 1'b1;
		cfg_index = CFG_WIN_WIDTH;
		cfg_data = WIN_W'(w);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		win_w = w;
		@(negedge clk);
		cfg_index = CFG_WIN_HEIGHT;
		cfg_data = WIN_W'(h);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		win_h = h;
		@(negedge clk);
		cfg_valid = 1'b0;
		n_windows++;
	endtask

	// mostly whole circles with random content, some cut short, some noise
	task automatic random_circles(input int quota);
		int base;
		int pick;
		int cut;
		base = n_items;
		while (n_items - base < quota) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				send_cmd(rand_advance());
			end else if (pick < 20) begin
				send_cmd(rand_start(1'b1));
				repeat ($urandom_range(0, 3)) send_cmd(rand_advance());
			end else begin
				send_cmd(rand_start(1'b0));
				cut = ($urandom_range(99) < 15) ? $urandom_range(1, 6) : 1000;
				while (running && cut > 0 && n_items - base < quota) begin
					send_cmd(rand_advance());
					cut--;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			n_err++;
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_words++;
			if (draw_q.size() == 0) begin
				n_err++;
				$display("%0t unexpected word: expected none actual kind %0d row %0d",
					$time, kind, row);
			end else begin
				seen = draw_q.pop_front();
				check_field("kind", int'(seen.kind), int'(kind));
				check_field("x_low", int'(seen.col_lo), int'(x_low));
				check_field("x_high", int'(seen.col_hi), int'(x_high));
				check_field("row", int'(seen.row_no), int'(row));
				check_field("color_out", int'(seen.color), int'(color_out));
				check_field("done_res", int'(seen.done), int'(done_res));
				check_field("last", int'(seen.last), int'(last));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYC) begin
			$display("timeout after %0d cycles, %0d words outstanding", n_cycles,
				draw_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_START;
		center_x = '0;
		center_y = '0;
		radius = '0;
		fill_request = 1'b0;
		pixel_color = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WIN_WIDTH;
		cfg_data = '0;
		hold_left = 0;
		tx_idle_pct = 18;
		rx_idle_pct = 18;
		win_w = WIN_WIDTH_RST;
		win_h = WIN_HEIGHT_RST;
		px_x = 0;
		px_y = 0;
		px_d = 0;
		ctr_c = 0;
		ctr_r = 0;
		filling = 1'b0;
		running = 1'b0;
		ink = '0;
		dir_tab = '{
			// advance out of reset, then a zero-radius circle at the origin
			'{1'b1, 1'b1, 24'h000000, '{ACT_ADVANCE, 12'sd77, -12'sd9, 10'd5, 1'b1, 24'h00ff00}},
			'{1'b1, 1'b0, 24'hffffff, '{ACT_START, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'hffffff}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			// small filled circle run to its end
			'{1'b0, 1'b0, 24'h0, '{ACT_START, 12'sd400, 12'sd250, 10'd10, 1'b1, 24'h123456}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			// field extremes, the second start dropping the running circle
			'{1'b0, 1'b0, 24'h0, '{ACT_START, 12'sd2047, 12'sd2047, 10'd1023, 1'b1, 24'h000000}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			'{1'b0, 1'b0, 24'h0, '{ACT_START, 12'sh800, 12'sh800, 10'd1023, 1'b1, 24'hffffff}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			// zero-length span
			'{1'b0, 1'b0, 24'h0, '{ACT_START, 12'sd1, 12'sd1, 10'd0, 1'b1, 24'h800001}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			// negative span starts, advances with junk in the unused fields
			'{1'b0, 1'b0, 24'h0, '{ACT_START, -12'sd5, 12'sd3, 10'd7, 1'b1, 24'haaaaaa}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd2047, 12'sh800, 10'd1023, 1'b1, 24'hffffff}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sh800, 12'sd2047, 10'd512, 1'b0, 24'h555555}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}},
			// top point just off the bottom edge of the window
			'{1'b0, 1'b0, 24'h0, '{ACT_START, 12'sd799, 12'sd499, 10'd1, 1'b0, 24'h5a5a5a}},
			'{1'b0, 1'b0, 24'h0, '{ACT_ADVANCE, 12'sd0, 12'sd0, 10'd0, 1'b0, 24'h0}}
		};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].t_done, dir_tab[i].t_color);
		end
		drain();

		// full rate on both sides for a while
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_window(2047, 2047);
		random_circles(60);
		drain();
		tx_idle_pct = 18;
		rx_idle_pct = 18;

		set_window(1, 1);
		random_circles(25);
		drain();
		set_window(0, 0);
		random_circles(15);
		drain();

		set_window($urandom_range(16, 300), $urandom_range(16, 300));
		random_circles(20);
		// output held off while words keep coming in
		hold_left = HOLD_CYC;
		random_circles(30);
		drain();
		random_circles(10);
		drain();

		set_window(WIN_WIDTH_RST, WIN_HEIGHT_RST);
		random_circles(40);
		drain();

		$display("%0d input words, %0d output words over %0d window settings",
			n_items, n_words, n_windows);
		$display("starts, restarts, idle advances, fill spans, window extremes, long stall");
		if (n_err == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
